// ----- hw/rtl/osm_pkg.sv -----
// Shared types and constants for the one-shot modifier controller.
// No dependencies; used by every module under hw/rtl.
`default_nettype none

package osm_pkg;

  localparam int unsigned KeyW   = 16;
  localparam int unsigned TimeW  = 16;
  localparam int unsigned CfgIdxW = 2;

  // Register indexes on the configuration port
  localparam logic [CfgIdxW-1:0] RegTrigger  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegModifier = 2'd1;
  localparam logic [CfgIdxW-1:0] RegToggle   = 2'd2;
  localparam logic [CfgIdxW-1:0] RegHold     = 2'd3;

  localparam logic [TimeW-1:0] ToggleRst = 16'd200;
  localparam logic [TimeW-1:0] HoldRst   = 16'd300;

  typedef enum logic [2:0] {
    ModeIdle       = 3'd0,
    ModeQueued     = 3'd1,
    ModeHeldUnused = 3'd2,
    ModeHeldUsed   = 3'd3,
    ModeLocked     = 3'd4
  } mode_e;

  typedef struct packed {
    logic [KeyW-1:0]  trigger_code;
    logic [KeyW-1:0]  modifier_code;
    logic [TimeW-1:0] toggle_window_ms;
    logic [TimeW-1:0] hold_limit_ms;
  } cfg_t;

  typedef struct packed {
    mode_e            mode;
    logic             pending_off;
    logic [TimeW-1:0] press_time;
  } state_t;

  // Field order matches tdata, lowest bits last in the declaration
  typedef struct packed {
    logic             is_ignored;
    logic             is_cancel;
    logic [TimeW-1:0] now_ms;
    logic             pressed;
    logic [KeyW-1:0]  key_code;
  } event_t;

  typedef struct packed {
    logic            pending_off_out;
    mode_e           mode;
    logic [KeyW-1:0] mod_out;
    logic            mod_release;
    logic            mod_press;
  } result_t;

  localparam int unsigned EventW  = $bits(event_t);
  localparam int unsigned ResultW = $bits(result_t);
  localparam int unsigned InDataW  = ((EventW + 7) / 8) * 8;
  localparam int unsigned OutDataW = ((ResultW + 7) / 8) * 8;

endpackage

`default_nettype wire

// ----- hw/rtl/osm_cfg_regs.sv -----
// Configuration register file for the one-shot modifier controller.
// Depends on osm_pkg.
`default_nettype none

module osm_cfg_regs (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          wr_en_i,
  input  wire logic [osm_pkg::CfgIdxW-1:0]   wr_index_i,
  input  wire logic [osm_pkg::KeyW-1:0]      wr_data_i,
  output osm_pkg::cfg_t                      cfg_o
);

  osm_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.trigger_code     <= '0;
      cfg_q.modifier_code    <= '0;
      cfg_q.toggle_window_ms <= osm_pkg::ToggleRst;
      cfg_q.hold_limit_ms    <= osm_pkg::HoldRst;
    end else if (wr_en_i) begin
      unique case (wr_index_i)
        osm_pkg::RegTrigger:  cfg_q.trigger_code     <= wr_data_i;
        osm_pkg::RegModifier: cfg_q.modifier_code    <= wr_data_i;
        osm_pkg::RegToggle:   cfg_q.toggle_window_ms <= wr_data_i;
        osm_pkg::RegHold:     cfg_q.hold_limit_ms    <= wr_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ----- hw/rtl/osm_step.sv -----
// Combinational next-state and result logic for one key event.
// Depends on osm_pkg.
`default_nettype none

module osm_step (
  input  wire osm_pkg::cfg_t    cfg_i,
  input  wire osm_pkg::state_t  state_i,
  input  wire osm_pkg::event_t  ev_i,
  output osm_pkg::state_t       state_o,
  output osm_pkg::result_t      result_o
);

  logic [osm_pkg::TimeW-1:0] elapsed;
  logic                      rq_press;
  logic                      rq_release;
  osm_pkg::state_t           nxt;

  // wrapping 16-bit subtraction
  assign elapsed = ev_i.now_ms - state_i.press_time;

  always_comb begin
    nxt        = state_i;
    rq_press   = 1'b0;
    rq_release = 1'b0;
    if (ev_i.key_code == cfg_i.trigger_code) begin
      if (ev_i.pressed) begin
        if (state_i.mode == osm_pkg::ModeLocked) begin
          nxt.mode   = osm_pkg::ModeIdle;
          rq_release = 1'b1;
        end else if (state_i.mode == osm_pkg::ModeQueued &&
                     elapsed < cfg_i.toggle_window_ms) begin
          nxt.mode = osm_pkg::ModeLocked;
        end else begin
          nxt.mode = osm_pkg::ModeHeldUnused;
          if (state_i.mode == osm_pkg::ModeIdle) begin
            rq_press       = 1'b1;
            nxt.press_time = ev_i.now_ms;
          end
        end
      end else begin
        if (state_i.mode == osm_pkg::ModeHeldUnused) begin
          if (elapsed > cfg_i.hold_limit_ms) begin
            nxt.mode   = osm_pkg::ModeIdle;
            rq_release = 1'b1;
          end else begin
            nxt.mode = osm_pkg::ModeQueued;
          end
        end else if (state_i.mode == osm_pkg::ModeHeldUsed) begin
          nxt.mode   = osm_pkg::ModeIdle;
          rq_release = 1'b1;
        end
      end
    end else if (ev_i.pressed) begin
      // cancel key and key rolling both force off; one release covers both
      if (ev_i.is_cancel && state_i.mode != osm_pkg::ModeIdle) begin
        nxt.mode   = osm_pkg::ModeIdle;
        rq_release = 1'b1;
      end
      if (state_i.pending_off && !ev_i.is_ignored) begin
        nxt.mode        = osm_pkg::ModeIdle;
        nxt.pending_off = 1'b0;
        rq_release      = 1'b1;
      end else if (nxt.mode == osm_pkg::ModeQueued && !ev_i.is_ignored) begin
        nxt.pending_off = 1'b1;
      end
    end else if (!ev_i.is_ignored) begin
      if (state_i.mode == osm_pkg::ModeHeldUnused) begin
        nxt.mode = osm_pkg::ModeHeldUsed;
      end else if (state_i.mode == osm_pkg::ModeQueued) begin
        nxt.mode        = osm_pkg::ModeIdle;
        nxt.pending_off = 1'b0;
        rq_release      = 1'b1;
      end
    end
  end

  assign state_o                  = nxt;
  assign result_o.mod_press       = rq_press;
  assign result_o.mod_release     = rq_release;
  assign result_o.mod_out         = cfg_i.modifier_code;
  assign result_o.mode            = nxt.mode;
  assign result_o.pending_off_out = nxt.pending_off;

endmodule

`default_nettype wire

// ----- hw/rtl/oneshot_modifier_fsm.sv -----
// Top level of the one-shot modifier key controller: stream ports,
// event register, state and result register. Depends on osm_pkg,
// osm_cfg_regs and osm_step.
`default_nettype none

// Channel   Dir  Handshake                      Payload
// s_axis    in   s_axis_tvalid / s_axis_tready  one key event in s_axis_tdata
// m_axis    out  m_axis_tvalid / m_axis_tready  one result per event
// cfg       in   cfg_valid_i / cfg_ready_o      register index + 16-bit data
//
// The result is registered after the input transfer: the event sits in
// the event register, then the mode update lands with the result register.
// One event per clock unless the output stalls; the limit is the state update.
// Reset clears mode, pending-off and press time and loads register defaults.
// A stalled output holds the result and the state; the event register still
// takes one more event, after which s_axis_tready drops.

module oneshot_modifier_fsm (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,

  input  wire logic                           s_axis_tvalid,
  output      logic                           s_axis_tready,
  // key_code[15:0], pressed[16], now_ms[32:17], is_cancel[33],
  // is_ignored[34], zero fill [39:35]
  input  wire logic [osm_pkg::InDataW-1:0]    s_axis_tdata,

  output      logic                           m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // mod_press[0], mod_release[1], mod_out[17:2], mode[20:18],
  // pending_off_out[21], zero fill [23:22]
  output      logic [osm_pkg::OutDataW-1:0]   m_axis_tdata,

  input  wire logic                           cfg_valid_i,
  output      logic                           cfg_ready_o,
  input  wire logic [osm_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  wire logic [osm_pkg::KeyW-1:0]       cfg_data_i
);

  osm_pkg::cfg_t    cfg;
  osm_pkg::event_t  ev_q;
  logic             ev_valid_q;
  osm_pkg::state_t  state_q, state_d;
  osm_pkg::result_t res_q, res_d;
  logic             res_valid_q;
  logic             advance;

  // registers accept writes at any time; software writes only when idle
  assign cfg_ready_o = 1'b1;

  osm_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  // result slot is free or drains this cycle
  assign advance       = !res_valid_q || m_axis_tready;
  assign s_axis_tready = !ev_valid_q || advance;

  // event register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ev_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      ev_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      ev_q <= osm_pkg::event_t'(s_axis_tdata[osm_pkg::EventW-1:0]);
    end
  end

  osm_step u_step (
    .cfg_i    (cfg),
    .state_i  (state_q),
    .ev_i     (ev_q),
    .state_o  (state_d),
    .result_o (res_d)
  );

  // mode state commits together with the result transfer into the output slot
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.mode        <= osm_pkg::ModeIdle;
      state_q.pending_off <= 1'b0;
      state_q.press_time  <= '0;
      res_valid_q         <= 1'b0;
    end else if (advance) begin
      res_valid_q <= ev_valid_q;
      if (ev_valid_q) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && ev_valid_q) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = res_valid_q;
  assign m_axis_tdata  = {{(osm_pkg::OutDataW - osm_pkg::ResultW){1'b0}}, res_q};

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------

  // a stalled result freezes the mode state
  a_state_frozen_on_stall : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> $stable(state_q))
  else $error("state changed while result stalled");

  // a press request only comes with the held-unused mode
  a_press_held : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && res_q.mod_press) |->
      (res_q.mode == osm_pkg::ModeHeldUnused && !res_q.mod_release))
  else $error("press request with wrong mode or release");

  // the shown mode is the committed mode
  a_mode_matches : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (res_q.mode == state_q.mode &&
                       res_q.pending_off_out == state_q.pending_off))
  else $error("result mode differs from state");

endmodule

`default_nettype wire

// ----- verif/testbench.sv -----
// Self-checking bench for oneshot_modifier_fsm: directed key sequences, then
// random phases under several register settings with stalls on both streams.
// Depends on osm_pkg and the RTL under hw/rtl.
`timescale 1ns / 1ps

// Shadow of the one-shot modifier state. It predicts one result per accepted
// key event and checks the results that come back, oldest first.
class OneshotShadow;
  osm_pkg::cfg_t    cfg;
  osm_pkg::mode_e   mode;
  logic             pending_off;
  logic [15:0]      press_time;
  osm_pkg::result_t pending_results[$];
  int               errors;

  function new();
    cfg.trigger_code     = '0;
    cfg.modifier_code    = '0;
    cfg.toggle_window_ms = osm_pkg::ToggleRst;
    cfg.hold_limit_ms    = osm_pkg::HoldRst;
    mode        = osm_pkg::ModeIdle;
    pending_off = 1'b0;
    press_time  = '0;
    errors      = 0;
  endfunction

  function void write_reg(logic [osm_pkg::CfgIdxW-1:0] idx, logic [15:0] data);
    case (idx)
      osm_pkg::RegTrigger:  cfg.trigger_code     = data;
      osm_pkg::RegModifier: cfg.modifier_code    = data;
      osm_pkg::RegToggle:   cfg.toggle_window_ms = data;
      osm_pkg::RegHold:     cfg.hold_limit_ms    = data;
      default: ;
    endcase
  endfunction

  function void flag(string msg);
    errors++;
    if (errors <= 10) $display("%s", msg);
  endfunction

  // Advance the shadow state by one key event and queue the expected result.
  function void note_event(osm_pkg::event_t ev);
    osm_pkg::result_t r;
    logic [15:0]      elapsed;
    logic             rq_press;
    logic             rq_release;
    elapsed    = ev.now_ms - press_time;  // wraps at 16 bits
    rq_press   = 1'b0;
    rq_release = 1'b0;
    if (ev.key_code == cfg.trigger_code) begin
      if (ev.pressed) begin
        if (mode == osm_pkg::ModeLocked) begin
          mode       = osm_pkg::ModeIdle;
          rq_release = 1'b1;
        end else begin
          if (mode == osm_pkg::ModeIdle) begin
            rq_press   = 1'b1;
            press_time = ev.now_ms;
            elapsed    = '0;
          end
          if (mode == osm_pkg::ModeQueued && elapsed < cfg.toggle_window_ms)
            mode = osm_pkg::ModeLocked;
          else
            mode = osm_pkg::ModeHeldUnused;
        end
      end else if (mode == osm_pkg::ModeHeldUnused) begin
        if (elapsed > cfg.hold_limit_ms) begin
          mode       = osm_pkg::ModeIdle;
          rq_release = 1'b1;
        end else begin
          mode = osm_pkg::ModeQueued;
        end
      end else if (mode == osm_pkg::ModeHeldUsed) begin
        mode       = osm_pkg::ModeIdle;
        rq_release = 1'b1;
      end
    end else if (ev.pressed) begin
      if (ev.is_cancel && mode != osm_pkg::ModeIdle) begin
        mode       = osm_pkg::ModeIdle;
        rq_release = 1'b1;
      end
      if (pending_off && !ev.is_ignored) begin
        mode        = osm_pkg::ModeIdle;
        rq_release  = 1'b1;
        pending_off = 1'b0;
      end else if (mode == osm_pkg::ModeQueued && !ev.is_ignored) begin
        pending_off = 1'b1;
      end
    end else if (!ev.is_ignored) begin
      if (mode == osm_pkg::ModeHeldUnused) begin
        mode = osm_pkg::ModeHeldUsed;
      end else if (mode == osm_pkg::ModeQueued) begin
        mode        = osm_pkg::ModeIdle;
        rq_release  = 1'b1;
        pending_off = 1'b0;
      end
    end
    r.mod_press       = rq_press;
    r.mod_release     = rq_release;
    r.mod_out         = cfg.modifier_code;
    r.mode            = mode;
    r.pending_off_out = pending_off;
    pending_results.push_back(r);
  endfunction

  function void check_result(osm_pkg::result_t got);
    osm_pkg::result_t want;
    if (pending_results.size() == 0) begin
      flag($sformatf("unexpected result %h with nothing outstanding", got));
      return;
    end
    want = pending_results.pop_front();
    if (got.mod_press !== want.mod_press || got.mod_release !== want.mod_release ||
        got.mod_out !== want.mod_out || got.mode !== want.mode ||
        got.pending_off_out !== want.pending_off_out)
      flag($sformatf({"mismatch: exp press=%0d rel=%0d mod=%h mode=%0d poff=%0d",
                      " | got press=%0d rel=%0d mod=%h mode=%0d poff=%0d"},
                     want.mod_press, want.mod_release, want.mod_out, want.mode,
                     want.pending_off_out, got.mod_press, got.mod_release,
                     got.mod_out, got.mode, got.pending_off_out));
  endfunction

  function void close_out();
    if (pending_results.size() != 0)
      flag($sformatf("%0d expected results never arrived", pending_results.size()));
  endfunction
endclass

module testbench;
  import osm_pkg::*;

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [KeyW-1:0]     cfg_data_i;

  OneshotShadow shadow = new();

  // Shared knobs for the stimulus.
  bit          calm;       // set: neither side idles
  logic [15:0] clock_ms;   // running millisecond timer fed into now_ms
  logic        trig_down;  // last pressed value sent for the trigger
  logic        other_down[3];

  oneshot_modifier_fsm dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // 20 ns clock
  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // Hard stop well beyond the slowest legitimate run.
  initial begin
    #20_000_000;
    $display("testbench: errors");
    $finish;
  end

  // Idle length for either side: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic event_t key_event(logic [15:0] code, logic dn, logic [15:0] t,
                                       logic cxl, logic ign);
    event_t ev;
    ev.key_code   = code;
    ev.pressed    = dn;
    ev.now_ms     = t;
    ev.is_cancel  = cxl;
    ev.is_ignored = ign;
    return ev;
  endfunction

  // Result side: ready toggles in runs and stalls, driven at the falling edge.
  initial begin
    int run_left;
    int stall_left;
    run_left      = 0;
    stall_left    = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        m_axis_tready = 1'b0;
        stall_left--;
      end else begin
        m_axis_tready = 1'b1;
        if (run_left > 0) begin
          run_left--;
        end else begin
          run_left   = $urandom_range(1, 24);
          stall_left = pick_gap();
        end
      end
    end
  end

  // Every result transfer is checked against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      shadow.check_result(result_t'(m_axis_tdata[ResultW-1:0]));
  end

  // One event transfer, with an optional idle gap in front. Valid stays high
  // when there is no gap, so back-to-back events follow without a break.
  task automatic push_event(input event_t ev);
    int gap;
    gap = pick_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tdata  = {{(InDataW - EventW){1'b0}}, ev};
    s_axis_tvalid = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    shadow.note_event(ev);
  endtask

  // Stop sending and wait until every outstanding result has come back.
  task automatic drain_results();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (shadow.pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [15:0] data);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    shadow.write_reg(idx, data);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // One random phase under a fixed register setting. Most traffic is the
  // trigger and three ordinary keys pressed and released in turn, with some time
  // steps aimed at the toggle and hold boundaries; the rest is noise.
  task automatic run_phase(input logic [15:0] trig, input logic [15:0] modc,
                           input logic [15:0] tog, input logic [15:0] hold,
                           input int count);
    event_t      ev;
    int          r;
    int          k;
    logic [15:0] others[3];
    write_reg(RegTrigger, trig);
    write_reg(RegModifier, modc);
    write_reg(RegToggle, tog);
    write_reg(RegHold, hold);
    for (int i = 0; i < 3; i++) others[i] = trig + 16'(i + 1);
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 99) < 3) calm = !calm;
      r = $urandom_range(0, 99);
      if (r < 50)
        clock_ms += 16'($urandom_range(0, 40));
      else if (r < 75)
        clock_ms += 16'($urandom_range(41, 400));
      else if (r < 82)
        clock_ms = 16'($urandom);
      else if (r < 91)  // one below, at, or one above the toggle window
        clock_ms = shadow.press_time + shadow.cfg.toggle_window_ms
                   + 16'($urandom_range(0, 2)) - 16'd1;
      else              // same around the hold limit
        clock_ms = shadow.press_time + shadow.cfg.hold_limit_ms
                   + 16'($urandom_range(0, 2)) - 16'd1;
      r = $urandom_range(0, 99);
      if (r < 45) begin
        ev.key_code = trig;
        ev.pressed  = ($urandom_range(0, 99) < 85) ? !trig_down : 1'($urandom);
        trig_down   = ev.pressed;
      end else if (r < 88) begin
        k             = $urandom_range(0, 2);
        ev.key_code   = others[k];
        ev.pressed    = ($urandom_range(0, 99) < 85) ? !other_down[k] : 1'($urandom);
        other_down[k] = ev.pressed;
      end else begin
        ev.key_code = 16'($urandom);
        ev.pressed  = 1'($urandom);
      end
      ev.now_ms     = clock_ms;
      ev.is_cancel  = ($urandom_range(0, 99) < 12);
      ev.is_ignored = ($urandom_range(0, 99) < 25);
      push_event(ev);
    end
    drain_results();
  endtask

  initial begin
    logic [15:0] tk;
    logic [15:0] ok;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = RegTrigger;
    cfg_data_i    = '0;
    calm          = 1'b0;
    clock_ms      = '0;
    trig_down     = 1'b0;
    for (int i = 0; i < 3; i++) other_down[i] = 1'b0;
    rst_ni        = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Register defaults: trigger is keycode 0, elapsed of 0xFFFF is a long hold.
    push_event(key_event(16'h0000, 1'b1, 16'h0000, 1'b0, 1'b0));
    push_event(key_event(16'h0000, 1'b0, 16'hFFFF, 1'b0, 1'b0));
    push_event(key_event(16'hFFFF, 1'b1, 16'hFFFF, 1'b1, 1'b1));
    drain_results();

    tk = 16'h0029;
    ok = 16'h0010;
    write_reg(RegTrigger, tk);
    write_reg(RegModifier, 16'h00E1);
    write_reg(RegToggle, 16'd200);
    write_reg(RegHold, 16'd300);
    // press across the timer wrap, quick release queues
    push_event(key_event(tk, 1'b1, 16'd65500, 1'b0, 1'b0));
    push_event(key_event(tk, 1'b0, 16'd100, 1'b0, 1'b0));
    // second press inside the window locks, a further press unlocks
    push_event(key_event(tk, 1'b1, 16'd150, 1'b0, 1'b0));
    push_event(key_event(tk, 1'b0, 16'd160, 1'b0, 1'b0));
    push_event(key_event(tk, 1'b1, 16'd190, 1'b0, 1'b0));
    // trigger press while held, then a hold past the limit acts like a plain mod
    push_event(key_event(tk, 1'b1, 16'd1000, 1'b0, 1'b0));
    push_event(key_event(tk, 1'b1, 16'd1010, 1'b0, 1'b0));
    push_event(key_event(tk, 1'b0, 16'd1400, 1'b0, 1'b0));
    // held, then used by another key, then trigger release drops it
    push_event(key_event(tk, 1'b1, 16'd2000, 1'b0, 1'b0));
    push_event(key_event(ok, 1'b1, 16'd2010, 1'b0, 1'b0));
    push_event(key_event(ok, 1'b0, 16'd2020, 1'b0, 1'b0));
    push_event(key_event(tk, 1'b0, 16'd2030, 1'b0, 1'b0));
    // queued; ignored press does nothing; rolling press arms pending-off;
    // cancel plus forced off in one press
    push_event(key_event(tk, 1'b1, 16'd3000, 1'b0, 1'b0));
    push_event(key_event(tk, 1'b0, 16'd3010, 1'b0, 1'b0));
    push_event(key_event(ok, 1'b1, 16'd3020, 1'b0, 1'b1));
    push_event(key_event(ok, 1'b1, 16'd3030, 1'b0, 1'b0));
    push_event(key_event(16'h0011, 1'b1, 16'd3040, 1'b1, 1'b0));
    // pending-off survives a lock and unlock, then forces off while idle
    push_event(key_event(tk, 1'b1, 16'd4000, 1'b0, 1'b0));
    push_event(key_event(tk, 1'b0, 16'd4010, 1'b0, 1'b0));
    push_event(key_event(ok, 1'b1, 16'd4020, 1'b0, 1'b0));
    push_event(key_event(tk, 1'b1, 16'd4030, 1'b0, 1'b0));
    push_event(key_event(tk, 1'b1, 16'd4040, 1'b0, 1'b0));
    push_event(key_event(ok, 1'b1, 16'd4050, 1'b0, 1'b0));
    // queued; late second press keeps time, its release passes the hold limit
    push_event(key_event(tk, 1'b1, 16'd5000, 1'b0, 1'b0));
    push_event(key_event(tk, 1'b0, 16'd5005, 1'b0, 1'b0));
    push_event(key_event(tk, 1'b1, 16'd5300, 1'b0, 1'b0));
    push_event(key_event(tk, 1'b0, 16'd5310, 1'b0, 1'b0));
    push_event(key_event(ok, 1'b0, 16'd5320, 1'b0, 1'b0));
    drain_results();

    // Random phases: typical, extremes with zero windows and with full windows,
    // tight windows, and fully random settings.
    run_phase(16'($urandom), 16'($urandom), 16'd200, 16'd300, 220);
    run_phase(16'h0000, 16'hFFFF, 16'h0000, 16'h0000, 220);
    run_phase(16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFF, 220);
    run_phase(16'($urandom), 16'($urandom), 16'($urandom_range(1, 50)),
              16'($urandom_range(1, 60)), 220);
    run_phase(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), 220);

    // Everything is back; give a stray extra result a chance to show up.
    repeat (8) @(posedge clk_i);
    shadow.close_out();
    if (shadow.errors == 0)
      $display("testbench: clean");
    else
      $display("testbench: errors");
    $finish;
  end

endmodule
